/* rtl/multicast_group_subscriber_table_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef MULTICAST_GROUP_SUBSCRIBER_TABLE_TOP_DEFINES_SVH
`define MULTICAST_GROUP_SUBSCRIBER_TABLE_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define MGST_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MGST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mgst_pkg.sv */
// ---------------------------------------------------------------------------
// mgst_pkg
// Shared sizes, codes and types of the multicast subscriber table.
// ---------------------------------------------------------------------------
package mgst_pkg;

    localparam int GROUP_SLOTS    = 16;
    localparam int SUBS_PER_GROUP = 16;
    localparam int N_ENTRIES      = GROUP_SLOTS * SUBS_PER_GROUP;
    localparam int GW             = $clog2(GROUP_SLOTS);
    localparam int SW             = $clog2(SUBS_PER_GROUP);
    localparam int EW             = GW + SW;
    localparam int CW             = $clog2(SUBS_PER_GROUP + 1);
    localparam int GCW            = $clog2(GROUP_SLOTS + 1);
    localparam int RW             = 9;

    localparam logic [CW-1:0] LIST_MAX = CW'(SUBS_PER_GROUP);

    localparam logic [2:0] MODE_LOOKUP  = 3'd0;
    localparam logic [2:0] MODE_ADD     = 3'd1;
    localparam logic [2:0] MODE_REMOVE  = 3'd2;
    localparam logic [2:0] MODE_RM_GRP  = 3'd3;
    localparam logic [2:0] MODE_REFRESH = 3'd4;
    localparam logic [2:0] MODE_EXPIRE  = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_LIST_FULL = 2'd2;
    localparam logic [1:0] ST_TBL_FULL  = 2'd3;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] egress;
        logic        pinned;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [1:0]    status;
        entry_t        ent;
        logic [CW-1:0] list_size;
        logic [RW-1:0] removed;
        logic          last;
    } result_t;

endpackage

/* rtl/mgst_entry_ram.sv */
// ---------------------------------------------------------------------------
// mgst_entry_ram
// Subscriber entry store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module mgst_entry_ram
    import mgst_pkg::*;
(
    input  logic          clk,
    input  logic          we,
    input  logic [EW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [EW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [N_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/multicast_group_subscriber_table_top.sv */
// ---------------------------------------------------------------------------
// multicast_group_subscriber_table_top
// Group to subscriber-list table with lookup, add, remove, refresh, expire.
// ---------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------------
//  input     | in_valid / in_ready   | mode, group_addr, sub_*, now_seconds
//  result    | out_valid / out_ready | status, out_*, list_size, removed, last
//  config    | cfg_we                | cfg_data (max_age)
//
// One beat in flight at a time; in_ready is high only when idle. Group search
// walks the slot registers one slot a cycle, then a dispatch step follows.
// Subscriber search reads, then compares, each entry visited; remove then
// reads the top entry and writes it over the hole. Lookup reads, captures
// and presents each listed entry in turn. Expire visits every slot, reads and
// checks each entry of a valid group and writes the top entry over each one
// removed. Reset clears the slot valid bits, sets max_age to 260 and idles
// the FSM; the entry RAM needs no clearing pass. Output stalls hold the FSM
// with its result.
module multicast_group_subscriber_table_top
    import mgst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [31:0] group_addr,
    input  logic [31:0] sub_ip,
    input  logic [15:0] sub_port,
    input  logic [15:0] sub_egress,
    input  logic        sub_is_static,
    input  logic [31:0] sub_stamp,
    input  logic [31:0] now_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] out_ip,
    output logic [15:0] out_port,
    output logic [15:0] out_egress,
    output logic        out_is_static,
    output logic [31:0] out_stamp,
    output logic [4:0]  list_size,
    output logic [8:0]  removed,
    output logic        last
);

    typedef enum logic [3:0] {
        S_IDLE, S_GSRCH, S_DISP, S_SRD, S_SCHK, S_LRD, S_LCAP,
        S_MVRD, S_MVWR, S_XNEXT, S_XRD, S_XCHK, S_XMVWR, S_OUT
    } state_t;

    state_t              state_reg;
    logic [31:0]         max_age_reg;
    logic [GROUP_SLOTS-1:0] gvalid_reg;
    logic [31:0]         gkey_reg   [GROUP_SLOTS];
    logic [CW-1:0]       gcount_reg [GROUP_SLOTS];

    logic [2:0]          mode_reg;
    logic [31:0]         gaddr_reg;
    entry_t              new_reg;
    logic [31:0]         now_reg;

    logic [GCW-1:0]      gscan_reg;   // slot under search
    logic                gfound_reg;
    logic [GW-1:0]       g_reg;
    logic                free_found_reg;
    logic [GW-1:0]       free_reg;
    logic [CW-1:0]       idx_reg;     // entry index under scan
    logic [SW-1:0]       hit_reg;
    logic [RW-1:0]       rem_reg;
    result_t             res_reg;

    logic                ram_we;
    logic [EW-1:0]       ram_waddr;
    entry_t              ram_wdata;
    logic [EW-1:0]       ram_raddr;
    entry_t              ram_rdata;

    mgst_entry_ram u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    logic [CW-1:0] cnt;
    logic [31:0]   age;
    logic [SW-1:0] top_idx;
    logic          sub_match;
    logic          hit;
    result_t       res_lookup;
    assign cnt       = gcount_reg[g_reg];
    assign age       = now_reg - ram_rdata.stamp;
    assign top_idx   = SW'(cnt - CW'(1));
    assign sub_match = ram_rdata.ip == new_reg.ip && ram_rdata.port == new_reg.port;
    // an empty list holds no entry to match
    assign hit       = (cnt != '0) && sub_match;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign status        = res_reg.status;
    assign out_ip        = res_reg.ent.ip;
    assign out_port      = res_reg.ent.port;
    assign out_egress    = res_reg.ent.egress;
    assign out_is_static = res_reg.ent.pinned;
    assign out_stamp     = res_reg.ent.stamp;
    assign list_size     = 5'(res_reg.list_size);
    assign removed       = res_reg.removed;
    assign last          = res_reg.last;

    // RAM port control: reads and the single write of a step.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {g_reg, top_idx};
        ram_wdata = ram_rdata;
        ram_raddr = {g_reg, SW'(idx_reg)};
        case (state_reg)
            S_MVRD:  ram_raddr = {g_reg, top_idx};
            S_MVWR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {g_reg, hit_reg};
            end
            // expire reads the entry below the scan index
            S_XRD:   ram_raddr = {g_reg, SW'(idx_reg - CW'(1))};
            // fetch the top entry in case the checked one goes
            S_XCHK:  ram_raddr = {g_reg, top_idx};
            S_XMVWR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {g_reg, SW'(idx_reg)};
            end
            S_SCHK:
            begin
                if (!hit && idx_reg + CW'(1) >= cnt && mode_reg == MODE_ADD
                    && cnt < LIST_MAX)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = {g_reg, SW'(cnt)};
                    ram_wdata = new_reg;
                end
                else if (hit && mode_reg == MODE_REFRESH)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = {g_reg, SW'(idx_reg)};
                    ram_wdata       = ram_rdata;
                    ram_wdata.stamp = now_reg;
                end
            end
            default: ;
        endcase
    end

    // Lookup beat built from the RAM data as it lands; last flag from index.
    always_comb
    begin
        res_lookup           = '0;
        res_lookup.status    = ST_OK;
        res_lookup.ent       = ram_rdata;
        res_lookup.list_size = cnt;
        res_lookup.last      = (idx_reg + CW'(1) >= cnt);
    end

    function automatic result_t simple(logic [1:0] st, logic [CW-1:0] sz,
                                       logic [RW-1:0] rm);
        result_t r;
        r           = '0;
        r.status    = st;
        r.list_size = sz;
        r.removed   = rm;
        r.last      = 1'b1;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            max_age_reg <= 32'd260;
            gvalid_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_age_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg         <= mode;
                        gaddr_reg        <= group_addr;
                        new_reg.ip       <= sub_ip;
                        new_reg.port     <= sub_port;
                        new_reg.egress   <= sub_egress;
                        new_reg.pinned   <= sub_is_static;
                        new_reg.stamp    <= sub_stamp;
                        now_reg          <= now_seconds;
                        gscan_reg        <= '0;
                        gfound_reg       <= 1'b0;
                        free_found_reg   <= 1'b0;
                        rem_reg          <= '0;
                        state_reg        <= (mode == MODE_EXPIRE) ? S_XNEXT : S_GSRCH;
                    end
                end
                // walk the slots: lowest match and lowest free slot
                S_GSRCH:
                begin
                    if (gscan_reg == GCW'(GROUP_SLOTS))
                    begin
                        state_reg <= S_DISP;
                    end
                    else
                    begin
                        if (gvalid_reg[GW'(gscan_reg)] && gkey_reg[GW'(gscan_reg)] == gaddr_reg
                            && !gfound_reg)
                        begin
                            gfound_reg <= 1'b1;
                            g_reg      <= GW'(gscan_reg);
                        end
                        if (!gvalid_reg[GW'(gscan_reg)] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_reg       <= GW'(gscan_reg);
                        end
                        gscan_reg <= gscan_reg + GCW'(1);
                    end
                end
                S_DISP:
                begin
                    idx_reg <= '0;
                    if (mode_reg > MODE_REFRESH)
                    begin
                        res_reg   <= simple(ST_NOT_FOUND, '0, '0);
                        state_reg <= S_OUT;
                    end
                    else if (!gfound_reg)
                    begin
                        if (mode_reg == MODE_ADD && free_found_reg)
                        begin
                            // fresh group: count 0, the compare step writes entry 0
                            g_reg                <= free_reg;
                            gvalid_reg[free_reg] <= 1'b1;
                            gkey_reg[free_reg]   <= gaddr_reg;
                            gcount_reg[free_reg] <= '0;
                            state_reg            <= S_SRD;
                        end
                        else
                        begin
                            res_reg <= simple((mode_reg == MODE_ADD) ? ST_TBL_FULL
                                                                     : ST_NOT_FOUND, '0, '0);
                            state_reg <= S_OUT;
                        end
                    end
                    else if (mode_reg == MODE_RM_GRP)
                    begin
                        gvalid_reg[g_reg] <= 1'b0;
                        gcount_reg[g_reg] <= '0;
                        res_reg   <= simple(ST_OK, '0, '0);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= (mode_reg == MODE_LOOKUP) ? S_LRD : S_SRD;
                    end
                end
                S_SRD:
                begin
                    state_reg <= S_SCHK;
                end
                S_SCHK:
                begin
                    if (hit)
                    begin
                        hit_reg <= SW'(idx_reg);
                        if (mode_reg == MODE_REMOVE)
                        begin
                            state_reg <= S_MVRD;
                        end
                        else
                        begin
                            res_reg   <= simple(ST_OK, cnt, '0);
                            state_reg <= S_OUT;
                        end
                    end
                    else if (idx_reg + CW'(1) >= cnt)
                    begin
                        if (mode_reg == MODE_ADD && cnt < LIST_MAX)
                        begin
                            gcount_reg[g_reg] <= cnt + CW'(1);
                            res_reg   <= simple(ST_OK, cnt + CW'(1), '0);
                        end
                        else if (mode_reg == MODE_ADD)
                        begin
                            res_reg <= simple(ST_LIST_FULL, cnt, '0);
                        end
                        else
                        begin
                            res_reg <= simple(ST_NOT_FOUND, cnt, '0);
                        end
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SRD;
                    end
                end
                S_MVRD:
                begin
                    state_reg <= S_MVWR;
                end
                // swap last into the hole, drop the tail
                S_MVWR:
                begin
                    gcount_reg[g_reg] <= cnt - CW'(1);
                    if (cnt == CW'(1))
                    begin
                        gvalid_reg[g_reg] <= 1'b0;
                    end
                    res_reg   <= simple(ST_OK, cnt - CW'(1), '0);
                    state_reg <= S_OUT;
                end
                S_LRD:
                begin
                    state_reg <= S_LCAP;
                end
                // RAM data read in S_LRD lands in the next cycle, here
                S_LCAP:
                begin
                    res_reg   <= res_lookup;
                    state_reg <= S_OUT;
                end
                // expire: pick next valid group, walk list downward
                S_XNEXT:
                begin
                    if (gscan_reg == GCW'(GROUP_SLOTS))
                    begin
                        res_reg   <= simple(ST_OK, '0, rem_reg);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        gscan_reg <= gscan_reg + GCW'(1);
                        if (gvalid_reg[GW'(gscan_reg)])
                        begin
                            g_reg     <= GW'(gscan_reg);
                            idx_reg   <= gcount_reg[GW'(gscan_reg)];
                            state_reg <= S_XRD;
                        end
                    end
                end
                S_XRD:
                begin
                    if (idx_reg == '0)
                    begin
                        if (cnt == '0)
                        begin
                            gvalid_reg[g_reg] <= 1'b0;
                        end
                        state_reg <= S_XNEXT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - CW'(1);
                        state_reg <= S_XCHK;
                    end
                end
                S_XCHK:
                begin
                    if (!ram_rdata.pinned && ram_rdata.stamp != '0
                        && age > max_age_reg)
                    begin
                        rem_reg   <= (rem_reg == '1) ? rem_reg : rem_reg + RW'(1);
                        state_reg <= S_XMVWR;
                    end
                    else
                    begin
                        state_reg <= S_XRD;
                    end
                end
                // top entry read in S_XCHK lands now; move it and shrink
                S_XMVWR:
                begin
                    gcount_reg[g_reg] <= cnt - CW'(1);
                    state_reg         <= S_XRD;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        if (res_reg.last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            // advance to the next listed entry
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_LRD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/mgst_checker.sv */
// ---------------------------------------------------------------------------
// mgst_checker
// Port-level checks of the subscriber table.
// ---------------------------------------------------------------------------
`include "multicast_group_subscriber_table_top_defines.svh"

module mgst_checker
    import mgst_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [4:0] list_size,
    input logic [8:0] removed,
    input logic       last
);

    `MGST_ASSERT_IMPL(a_busy, clk, rst_n, out_valid, !in_ready, "ready while result pending")
    `MGST_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status), "result dropped")
    `MGST_ASSERT_IMPL(a_size, clk, rst_n, out_valid, list_size <= 5'(SUBS_PER_GROUP), "size out of range")
    `MGST_ASSERT_IMPL(a_rm, clk, rst_n, out_valid && removed != 9'd0, last && status == ST_OK, "removed on bad beat")
    `MGST_ASSERT_NEXT(a_take, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accepted beat")

endmodule

bind multicast_group_subscriber_table_top mgst_checker u_chk (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Subscriber table testbench
// Drives membership, lookup, refresh and expire beats into the table and
// checks every result beat against a behavioural table model.
// ---------------------------------------------------------------------------
module tb_top;
    import mgst_pkg::*;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] gaddr;
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] egress;
        logic        pinned;
        logic [31:0] stamp;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] egress;
        logic        pinned;
        logic [31:0] stamp;
        logic [4:0]  size;
        logic [8:0]  removed;
        logic        last;
    } rsp_t;

    localparam int LIMIT = 3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  mode = '0;
    logic [31:0] group_addr = '0;
    logic [31:0] sub_ip = '0;
    logic [15:0] sub_port = '0;
    logic [15:0] sub_egress = '0;
    logic        sub_is_static = 1'b0;
    logic [31:0] sub_stamp = '0;
    logic [31:0] now_seconds = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [31:0] out_ip;
    logic [15:0] out_port;
    logic [15:0] out_egress;
    logic        out_is_static;
    logic [31:0] out_stamp;
    logic [4:0]  list_size;
    logic [8:0]  removed;
    logic        last;

    multicast_group_subscriber_table_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .group_addr(group_addr), .sub_ip(sub_ip), .sub_port(sub_port),
        .sub_egress(sub_egress), .sub_is_static(sub_is_static),
        .sub_stamp(sub_stamp), .now_seconds(now_seconds),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .out_ip(out_ip), .out_port(out_port), .out_egress(out_egress),
        .out_is_static(out_is_static), .out_stamp(out_stamp),
        .list_size(list_size), .removed(removed), .last(last)
    );

    always #6 clk = ~clk;

    // Table model: its own copy of slots, lists and the age register.
    logic [31:0] age_limit;
    logic        slot_used [GROUP_SLOTS];
    logic [31:0] slot_key [GROUP_SLOTS];
    int          slot_count [GROUP_SLOTS];
    entry_t      subs [GROUP_SLOTS][SUBS_PER_GROUP];

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   errors = 0;
    int   accepted = 0;
    int   rsp_seen = 0;
    int   cycles = 0;
    bit   stim_done = 1'b0;
    bit   hold_send = 1'b0;
    bit   in_taken = 1'b0;

    // Keys from a small pool so groups collide and fill up.
    logic [31:0] key_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hE000_0001,
                                  32'hE000_0002, 32'hEFFF_FFFA, 32'h1234_5678};
    logic [31:0] ip_pool [4] = '{32'h0, 32'hFFFF_FFFF, 32'h0A00_0001, 32'h0A00_0002};

    function automatic rsp_t short_rsp(logic [1:0] st, int sz, int rm);
        rsp_t r;
        r = '0;
        r.status = st;
        r.size = sz[4:0];
        r.removed = rm[8:0];
        r.last = 1'b1;
        return r;
    endfunction

    function automatic int find_slot(logic [31:0] key);
        for (int g = 0; g < GROUP_SLOTS; g++)
            if (slot_used[g] && slot_key[g] == key)
                return g;
        return -1;
    endfunction

    function automatic int find_member(int g, logic [31:0] ip, logic [15:0] port);
        for (int i = 0; i < slot_count[g]; i++)
            if (subs[g][i].ip == ip && subs[g][i].port == port)
                return i;
        return -1;
    endfunction

    function automatic void drop_member(int g, int i);
        slot_count[g]--;
        if (i < slot_count[g])
            subs[g][i] = subs[g][slot_count[g]];
    endfunction

    // Work out the result beats of one request and update the model.
    function automatic void predict_table(req_t q);
        int g;
        int s;
        int total;
        rsp_t r;
        g = find_slot(q.gaddr);
        case (q.mode)
            MODE_LOOKUP:
                if (g < 0)
                    expected_rsps.push_back(short_rsp(ST_NOT_FOUND, 0, 0));
                else
                    for (int i = 0; i < slot_count[g]; i++)
                    begin
                        r = '0;
                        r.status = ST_OK;
                        r.ip = subs[g][i].ip;
                        r.port = subs[g][i].port;
                        r.egress = subs[g][i].egress;
                        r.pinned = subs[g][i].pinned;
                        r.stamp = subs[g][i].stamp;
                        r.size = slot_count[g][4:0];
                        r.last = (i + 1 == slot_count[g]);
                        expected_rsps.push_back(r);
                    end
            MODE_ADD:
            begin
                if (g >= 0 && find_member(g, q.ip, q.port) >= 0)
                begin
                    expected_rsps.push_back(short_rsp(ST_OK, slot_count[g], 0));
                    return;
                end
                if (g >= 0 && slot_count[g] >= SUBS_PER_GROUP)
                begin
                    expected_rsps.push_back(short_rsp(ST_LIST_FULL, slot_count[g], 0));
                    return;
                end
                if (g < 0)
                begin
                    for (g = 0; g < GROUP_SLOTS; g++)
                        if (!slot_used[g])
                            break;
                    if (g >= GROUP_SLOTS)
                    begin
                        expected_rsps.push_back(short_rsp(ST_TBL_FULL, 0, 0));
                        return;
                    end
                    slot_used[g] = 1'b1;
                    slot_key[g] = q.gaddr;
                    slot_count[g] = 0;
                end
                subs[g][slot_count[g]] = '{q.ip, q.port, q.egress, q.pinned, q.stamp};
                slot_count[g]++;
                expected_rsps.push_back(short_rsp(ST_OK, slot_count[g], 0));
            end
            MODE_REMOVE, MODE_REFRESH:
            begin
                if (g < 0)
                begin
                    expected_rsps.push_back(short_rsp(ST_NOT_FOUND, 0, 0));
                    return;
                end
                s = find_member(g, q.ip, q.port);
                if (s < 0)
                begin
                    expected_rsps.push_back(short_rsp(ST_NOT_FOUND, slot_count[g], 0));
                    return;
                end
                if (q.mode == MODE_REFRESH)
                    subs[g][s].stamp = q.now;
                else
                begin
                    drop_member(g, s);
                    if (slot_count[g] == 0)
                        slot_used[g] = 1'b0;
                end
                expected_rsps.push_back(short_rsp(ST_OK, slot_count[g], 0));
            end
            MODE_RM_GRP:
                if (g < 0)
                    expected_rsps.push_back(short_rsp(ST_NOT_FOUND, 0, 0));
                else
                begin
                    slot_used[g] = 1'b0;
                    slot_count[g] = 0;
                    expected_rsps.push_back(short_rsp(ST_OK, 0, 0));
                end
            MODE_EXPIRE:
            begin
                total = 0;
                for (int h = 0; h < GROUP_SLOTS; h++)
                begin
                    if (!slot_used[h])
                        continue;
                    for (int k = slot_count[h] - 1; k >= 0; k--)
                        if (!subs[h][k].pinned && subs[h][k].stamp != 0 &&
                            (q.now - subs[h][k].stamp) > age_limit)
                        begin
                            drop_member(h, k);
                            total++;
                        end
                    if (slot_count[h] == 0)
                        slot_used[h] = 1'b0;
                end
                expected_rsps.push_back(short_rsp(ST_OK, 0, total > 511 ? 511 : total));
            end
            default:
                expected_rsps.push_back(short_rsp(ST_NOT_FOUND, 0, 0));
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch on result %0d: %s got %0h want %0h", rsp_seen, what, got, want);
    endtask

    // Random request: mostly well-formed traffic on a small key and member pool.
    function automatic req_t random_req();
        req_t q;
        int pick;
        q.gaddr = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 5)];
        q.ip = ($urandom_range(0, 7) == 0) ? $urandom() : ip_pool[$urandom_range(0, 3)];
        q.port = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 5));
        if ($urandom_range(0, 9) == 0)
            q.port = 16'hFFFF;
        q.egress = 16'($urandom());
        q.pinned = $urandom_range(0, 3) == 0;
        q.stamp = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(0, 1000);
        if ($urandom_range(0, 15) == 0)
            q.stamp = $urandom();
        q.now = $urandom_range(0, 1400);
        if ($urandom_range(0, 15) == 0)
            q.now = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 40)
            q.mode = MODE_ADD;
        else if (pick < 60)
            q.mode = MODE_LOOKUP;
        else if (pick < 70)
            q.mode = MODE_REMOVE;
        else if (pick < 75)
            q.mode = MODE_RM_GRP;
        else if (pick < 85)
            q.mode = MODE_REFRESH;
        else if (pick < 95)
            q.mode = MODE_EXPIRE;
        else
            q.mode = 3'($urandom_range(6, 7));
        return q;
    endfunction

    function automatic req_t make_req(logic [2:0] m, logic [31:0] ga, logic [31:0] ip,
                                      logic [15:0] pt, logic st, logic [31:0] stp,
                                      logic [31:0] nw);
        return '{m, ga, ip, pt, 16'hFFFF ^ pt, st, stp, nw};
    endfunction

    // Wait for an empty pipe, then hold a little for any trailing work.
    task automatic drain_table();
        wait (pending_reqs.size() == 0 && !in_valid && expected_rsps.size() == 0);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_age(logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        age_limit = v;
    endtask

    // Stimulus.
    initial
    begin
        age_limit = 32'd260;
        for (int g = 0; g < GROUP_SLOTS; g++)
        begin
            slot_used[g] = 1'b0;
            slot_count[g] = 0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: misses, extremes, duplicate, full list, full table, expire corners.
        pending_reqs.push_back(make_req(MODE_LOOKUP, 32'hE000_0001, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(MODE_REMOVE, 32'hE000_0001, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(MODE_REFRESH, 32'hE000_0001, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(MODE_RM_GRP, 32'hE000_0001, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        16'hFFFF, 1, 32'hFFFF_FFFF, 0));
        pending_reqs.push_back(make_req(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        16'hFFFF, 0, 32'd5, 0));
        pending_reqs.push_back(make_req(MODE_ADD, 32'hFFFF_FFFF, 0, 0, 0, 32'd0, 0));
        pending_reqs.push_back(make_req(MODE_ADD, 32'hFFFF_FFFF, 1, 1, 0, 32'd10, 0));
        pending_reqs.push_back(make_req(MODE_REFRESH, 32'hFFFF_FFFF, 9, 9, 0, 0, 7));
        pending_reqs.push_back(make_req(MODE_REFRESH, 32'hFFFF_FFFF, 1, 1, 0, 0, 32'd20));
        pending_reqs.push_back(make_req(MODE_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(MODE_EXPIRE, 0, 0, 0, 0, 0, 32'd280));
        pending_reqs.push_back(make_req(MODE_EXPIRE, 0, 0, 0, 0, 0, 32'd281));
        pending_reqs.push_back(make_req(MODE_REMOVE, 32'hFFFF_FFFF, 9, 9, 0, 0, 0));
        pending_reqs.push_back(make_req(MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        16'hFFFF, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd6, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd7, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < SUBS_PER_GROUP + 1; i++)
            pending_reqs.push_back(make_req(MODE_ADD, 32'hE000_0002, i, 16'(i), 0,
                                            32'd100, 0));
        pending_reqs.push_back(make_req(MODE_LOOKUP, 32'hE000_0002, 0, 0, 0, 0, 0));
        for (int g = 0; g < GROUP_SLOTS + 1; g++)
            pending_reqs.push_back(make_req(MODE_ADD, 32'hD000_0000 + g, 5, 5, 0, 32'd50, 0));
        pending_reqs.push_back(make_req(MODE_EXPIRE, 0, 0, 0, 0, 0, 32'd40));
        pending_reqs.push_back(make_req(MODE_RM_GRP, 32'hE000_0002, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(MODE_EXPIRE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        drain_table();

        // Random phases over several age limits, extremes included.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_age(32'd0);
                1: write_age(32'hFFFF_FFFF);
                2: write_age($urandom_range(1, 600));
                3: write_age($urandom());
                default: write_age(32'd260);
            endcase
            for (int n = 0; n < 81; n++)
            begin
                pending_reqs.push_back(random_req());
                if (n == 40)
                begin
                    // Hold the sender until the table has answered everything.
                    wait (pending_reqs.size() == 0 && !in_valid);
                    hold_send = 1'b1;
                    wait (expected_rsps.size() == 0);
                    @(negedge clk);
                    hold_send = 1'b0;
                end
            end
            drain_table();
        end
        stim_done = 1'b1;
    end

    // Driver: bursts of beats with random gaps, changed on the falling edge.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (in_valid && !in_taken)
        begin
            // hold the beat until it is taken
        end
        else
        begin
            in_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0 && !hold_send && rst_n)
            begin
                req_t q;
                q = pending_reqs.pop_front();
                in_valid <= 1'b1;
                {mode, group_addr, sub_ip, sub_port, sub_egress, sub_is_static, sub_stamp,
                 now_seconds} <= q;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 8);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            else
                in_valid <= 1'b0;
        end
        // Receiver: stall on long and short stretches of its own.
        out_ready <= ((cycles / 300) % 3 == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    // Monitor: take accepted beats on the rising edge and compare them.
    always @(posedge clk)
    begin
        cycles++;
        if (in_valid && in_ready)
        begin
            predict_table({mode, group_addr, sub_ip, sub_port, sub_egress, sub_is_static,
                           sub_stamp, now_seconds});
            accepted++;
            in_taken = 1'b1;
        end
        if (out_valid && out_ready)
        begin
            rsp_t w;
            rsp_seen++;
            if (expected_rsps.size() == 0)
            begin
                errors++;
                $display("unexpected result beat %0d", rsp_seen);
            end
            else
            begin
                w = expected_rsps.pop_front();
                if (status !== w.status) report_mismatch("status", status, w.status);
                if (out_ip !== w.ip) report_mismatch("out_ip", out_ip, w.ip);
                if (out_port !== w.port) report_mismatch("out_port", out_port, w.port);
                if (out_egress !== w.egress)
                    report_mismatch("out_egress", out_egress, w.egress);
                if (out_is_static !== w.pinned)
                    report_mismatch("out_is_static", out_is_static, w.pinned);
                if (out_stamp !== w.stamp) report_mismatch("out_stamp", out_stamp, w.stamp);
                if (list_size !== w.size) report_mismatch("list_size", list_size, w.size);
                if (removed !== w.removed) report_mismatch("removed", removed, w.removed);
                if (last !== w.last) report_mismatch("last", last, w.last);
            end
        end
    end

    // End of run: finish after the drain, or on the cycle limit.
    initial
    begin
        wait (stim_done || cycles >= LIMIT);
        if (!stim_done)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
        end
        else
        begin
            if (expected_rsps.size() != 0)
            begin
                errors++;
                $display("%0d expected results never arrived", expected_rsps.size());
            end
            $display("covered %0d request beats and %0d result beats over six age limits",
                     accepted, rsp_seen);
            if (errors == 0)
                $display("== PASS ==");
            else
                $display("== FAIL ==");
        end
        $finish;
    end
endmodule

/* multicast_group_subscriber_table_top.f */
+incdir+rtl
rtl/mgst_pkg.sv
rtl/mgst_entry_ram.sv
rtl/multicast_group_subscriber_table_top.sv
rtl/mgst_checker.sv
bench/tb_top.sv
